[sv/sact_pkg.sv]
// Shared types, codes and default sizes of the set-associative cache tag store.
package sact_pkg;

  localparam int unsigned DEF_NUM_SETS = 64;
  localparam int unsigned DEF_NUM_WAYS = 8;
  localparam int unsigned DEF_TAG_BITS = 32;

  localparam int unsigned SET_IDX_W = 6;
  localparam int unsigned TAG_IN_W  = 32;
  localparam int unsigned WAY_OUT_W = 3;

  localparam logic REG_POLICY = 1'b0;

  typedef enum logic [1:0] {
    POL_LRU  = 2'd0,
    POL_FIFO = 2'd1,
    POL_PLRU = 2'd2,
    POL_RSVD = 2'd3
  } policy_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOOKUP,
    BK_WRITE
  } back_state_e;

  typedef struct packed {
    logic                 func;
    logic [SET_IDX_W-1:0] set_index;
    logic [TAG_IN_W-1:0]  tag;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic                 fetch_next_level;
    logic [WAY_OUT_W-1:0] way_used;
    logic                 evicted;
    logic                 writeback;
    logic [TAG_IN_W-1:0]  victim_tag;
  } out_item_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

[sv/sact_queue.sv]
// Small first-in first-out queue that decouples two sides of the block.
module sact_queue
  import sact_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[sv/sact_back.sv]
// Lookup, victim choice and set update engine with the tag and state memories.
module sact_back
  import sact_pkg::*;
#(
  parameter int unsigned NUM_SETS = DEF_NUM_SETS,
  parameter int unsigned NUM_WAYS = DEF_NUM_WAYS,
  parameter int unsigned TAG_BITS = DEF_TAG_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  policy_e      policy_i,
  input  in_item_t     req_i,
  input  logic         req_valid_i,
  output logic         req_pop_o,
  input  logic         rsp_full_i,
  output logic         rsp_push_o,
  output out_item_t    rsp_o,
  output back_status_t status_o
);

  localparam int unsigned WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned RANK_W = WAY_W;
  localparam int unsigned SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned PLRU_W = (NUM_WAYS > 1) ? NUM_WAYS - 1 : 1;
  localparam int unsigned LEVELS = $clog2(NUM_WAYS) + 1;
  localparam int unsigned SET_IN = 2 ** SET_IDX_W;
  localparam logic [PLRU_W-1:0] PLRU_RST = (NUM_WAYS > 1) ? {PLRU_W{1'b1}} : '0;

  typedef logic [NUM_WAYS-1:0][RANK_W-1:0] rank_row_t;

  // Set index wrap as a constant table.
  logic [SET_W-1:0] set_map [SET_IN];
  for (genvar g = 0; g < SET_IN; g++) begin : g_map
    assign set_map[g] = SET_W'(g % NUM_SETS);
  end

  function automatic rank_row_t rank_touch(rank_row_t r, logic [WAY_W-1:0] way);
    rank_row_t         o;
    logic [RANK_W-1:0] old;
    o   = r;
    old = r[way];
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (r[i] > old) begin
        o[i] = r[i] - 1'b1;
      end
    end
    o[way] = RANK_W'(NUM_WAYS - 1);
    return o;
  endfunction

  function automatic logic [WAY_W-1:0] rank_victim(rank_row_t r);
    logic [WAY_W-1:0] best;
    best = '0;
    for (int i = 1; i < NUM_WAYS; i++) begin
      if (r[i] < r[best]) begin
        best = WAY_W'(i);
      end
    end
    return best;
  endfunction

  function automatic logic [PLRU_W-1:0] tree_touch(logic [PLRU_W-1:0] b,
                                                   logic [WAY_W-1:0] way);
    logic [PLRU_W-1:0] o;
    int unsigned       node, parent;
    o    = b;
    node = int'(way) + NUM_WAYS - 1;
    for (int l = 0; l < LEVELS; l++) begin
      if (node != 0) begin
        parent = (node - 1) >> 1;
        o[parent] = node[0];
        node = parent;
      end
    end
    return o;
  endfunction

  function automatic logic [WAY_W-1:0] tree_victim(logic [PLRU_W-1:0] b);
    int unsigned node;
    node = 0;
    for (int l = 0; l < LEVELS; l++) begin
      if (node < NUM_WAYS - 1) begin
        node = b[node] ? 2 * node + 2 : 2 * node + 1;
      end
    end
    return WAY_W'(node - (NUM_WAYS - 1));
  endfunction

  // Memories, one row per set.
  logic [NUM_WAYS-1:0][TAG_BITS-1:0] tag_mem [NUM_SETS];
  logic [NUM_WAYS-1:0]               valid_mem [NUM_SETS];
  logic [NUM_WAYS-1:0]               dirty_mem [NUM_SETS];
  rank_row_t                         rr_mem [NUM_SETS];
  rank_row_t                         ir_mem [NUM_SETS];
  logic [PLRU_W-1:0]                 plru_mem [NUM_SETS];

  logic [NUM_WAYS-1:0][TAG_BITS-1:0] tag_rd_q, tag_wr;
  logic [NUM_WAYS-1:0]               valid_rd_q, valid_wr, dirty_rd_q, dirty_wr;
  rank_row_t                         rr_rd_q, rr_wr, ir_rd_q, ir_wr;
  logic [PLRU_W-1:0]                 plru_rd_q, plru_wr;

  back_state_e       st_q, st_d;
  logic [SET_W-1:0]  clr_q, clr_d, set_q, rd_addr, wr_addr;
  logic [TAG_BITS-1:0] tag_q, victim_q, tag_in;
  logic              func_q;
  logic              hit_q, evict_q, wb_q;
  logic [WAY_W-1:0]  way_q;
  logic              meta_we, tag_we;

  logic              lk_hit, lk_free;
  logic [WAY_W-1:0]  lk_hit_way, lk_free_way, lk_vict_way, lk_way;

  assign tag_in  = TAG_BITS'(req_i.tag);
  assign rd_addr = set_map[req_i.set_index];

  // Next state.
  always_comb begin
    st_d  = st_q;
    clr_d = clr_q;
    case (st_q)
      BK_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == SET_W'(NUM_SETS - 1)) begin
          st_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (req_valid_i && !rsp_full_i) begin
          st_d = BK_LOOKUP;
        end
      end
      BK_LOOKUP: st_d = BK_WRITE;
      BK_WRITE:  st_d = BK_IDLE;
      default:   st_d = BK_IDLE;
    endcase
  end

  // Outputs and memory strobes.
  always_comb begin
    req_pop_o         = 1'b0;
    rsp_push_o        = 1'b0;
    meta_we           = 1'b0;
    tag_we            = 1'b0;
    status_o.clearing = 1'b0;
    wr_addr           = set_q;
    case (st_q)
      BK_CLEAR: begin
        status_o.clearing = 1'b1;
        meta_we           = 1'b1;
        wr_addr           = clr_q;
      end
      BK_IDLE:   req_pop_o = req_valid_i && !rsp_full_i;
      BK_LOOKUP: ;
      BK_WRITE: begin
        rsp_push_o = 1'b1;
        meta_we    = 1'b1;
        tag_we     = 1'b1;
      end
      default: ;
    endcase
  end

  // Lookup on the row read out of the memories.
  always_comb begin
    lk_hit      = 1'b0;
    lk_hit_way  = '0;
    lk_free     = 1'b0;
    lk_free_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (valid_rd_q[w] && tag_rd_q[w] == tag_q) begin
        lk_hit     = 1'b1;
        lk_hit_way = WAY_W'(w);
      end
      if (!valid_rd_q[w]) begin
        lk_free     = 1'b1;
        lk_free_way = WAY_W'(w);
      end
    end
    case (policy_i)
      POL_FIFO: lk_vict_way = rank_victim(ir_rd_q);
      POL_PLRU: lk_vict_way = tree_victim(plru_rd_q);
      default:  lk_vict_way = rank_victim(rr_rd_q);
    endcase
    if (lk_hit) begin
      lk_way = lk_hit_way;
    end else if (lk_free) begin
      lk_way = lk_free_way;
    end else begin
      lk_way = lk_vict_way;
    end
  end

  // Updated row of the set.
  always_comb begin
    tag_wr   = tag_rd_q;
    valid_wr = valid_rd_q;
    dirty_wr = dirty_rd_q;
    rr_wr    = rr_rd_q;
    ir_wr    = ir_rd_q;
    plru_wr  = plru_rd_q;
    if (status_o.clearing) begin
      valid_wr = '0;
      dirty_wr = '0;
      rr_wr    = '0;
      ir_wr    = '0;
      plru_wr  = PLRU_RST;
    end else begin
      if (hit_q) begin
        if (func_q) begin
          dirty_wr[way_q] = 1'b1;
        end
      end else begin
        tag_wr[way_q]   = tag_q;
        valid_wr[way_q] = 1'b1;
        dirty_wr[way_q] = func_q;
      end
      case (policy_i)
        POL_FIFO: begin
          if (!hit_q) begin
            ir_wr = rank_touch(ir_rd_q, way_q);
          end
        end
        POL_PLRU: plru_wr = tree_touch(plru_rd_q, way_q);
        default:  rr_wr = rank_touch(rr_rd_q, way_q);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= BK_CLEAR;
      clr_q <= '0;
    end else begin
      st_q  <= st_d;
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      set_q  <= rd_addr;
      tag_q  <= tag_in;
      func_q <= req_i.func;
    end
    if (st_q == BK_LOOKUP) begin
      hit_q    <= lk_hit;
      way_q    <= lk_way;
      evict_q  <= !lk_hit && !lk_free;
      wb_q     <= !lk_hit && !lk_free && dirty_rd_q[lk_vict_way];
      victim_q <= (!lk_hit && !lk_free) ? tag_rd_q[lk_vict_way] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[wr_addr] <= tag_wr;
    end
    if (req_pop_o) begin
      tag_rd_q <= tag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      valid_mem[wr_addr] <= valid_wr;
      dirty_mem[wr_addr] <= dirty_wr;
      rr_mem[wr_addr]    <= rr_wr;
      ir_mem[wr_addr]    <= ir_wr;
      plru_mem[wr_addr]  <= plru_wr;
    end
    if (req_pop_o) begin
      valid_rd_q <= valid_mem[rd_addr];
      dirty_rd_q <= dirty_mem[rd_addr];
      rr_rd_q    <= rr_mem[rd_addr];
      ir_rd_q    <= ir_mem[rd_addr];
      plru_rd_q  <= plru_mem[rd_addr];
    end
  end

  assign rsp_o.hit              = hit_q;
  assign rsp_o.fetch_next_level = !hit_q;
  assign rsp_o.way_used         = WAY_OUT_W'(way_q);
  assign rsp_o.evicted          = evict_q;
  assign rsp_o.writeback        = wb_q;
  assign rsp_o.victim_tag       = TAG_IN_W'(victim_q);

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == BK_CLEAR |-> !req_pop_o)
    else $error("item taken during clearing pass");

  a_pop_then_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_pop_o |=> st_q == BK_LOOKUP && !rsp_push_o)
    else $error("popped item not looked up");

  a_single_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_push_o |=> !rsp_push_o && !req_pop_o || st_q == BK_IDLE)
    else $error("result pushed twice");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_push_o && rsp_o.hit |-> !rsp_o.evicted && !rsp_o.writeback &&
                                rsp_o.victim_tag == '0)
    else $error("hit reports an eviction");

endmodule

[sv/set_assoc_cache_tag_replacement.sv]
// Top level: configuration register, input and result queues, and the update engine.
// An accepted transfer passes the input queue, then the read, lookup and write of its set row.
// No new access starts before the last set row is written, nor while the result queue is full.
// The input queue holds two accesses and the result queue two results, so both sides stall alone.
// Reset: asynchronous, active low; then a clearing pass over all NUM_SETS sets holds full high.
// The replacement policy register resets to true LRU.
module set_assoc_cache_tag_replacement
  import sact_pkg::*;
#(
  parameter int unsigned NUM_SETS = DEF_NUM_SETS,
  parameter int unsigned NUM_WAYS = DEF_NUM_WAYS,
  parameter int unsigned TAG_BITS = DEF_TAG_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    req_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // The user must see that the policy register is written only while the block is idle, so
  // the engine reads it directly; the block itself does not enforce this.
  policy_e      policy_q;
  logic         in_full, in_empty, in_push, bk_pop, rs_full, rs_push;
  logic [$bits(in_item_t)-1:0]  in_head;
  logic [$bits(out_item_t)-1:0] rs_head;
  in_item_t     bk_req;
  out_item_t    bk_rsp;
  back_status_t bk_status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_POLICY) ? {30'd0, policy_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_LRU;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_POLICY) begin
      policy_q <= policy_e'(pwdata[1:0]);
    end
  end

  // No transfer is taken while the state memories are being cleared.
  assign full    = in_full || bk_status.clearing;
  assign in_push = push && !bk_status.clearing;

  sact_queue #(
    .WIDTH ($bits(in_item_t)),
    .DEPTH (2)
  ) u_in_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_push),
    .data_i  (req_i),
    .full_o  (in_full),
    .pop_i   (bk_pop),
    .data_o  (in_head),
    .empty_o (in_empty)
  );

  assign bk_req = in_item_t'(in_head);

  sact_back #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS),
    .TAG_BITS (TAG_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .policy_i    (policy_q),
    .req_i       (bk_req),
    .req_valid_i (!in_empty),
    .req_pop_o   (bk_pop),
    .rsp_full_i  (rs_full),
    .rsp_push_o  (rs_push),
    .rsp_o       (bk_rsp),
    .status_o    (bk_status)
  );

  // Results wait here until the consumer takes them.
  sact_queue #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (2)
  ) u_rsp_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rs_push),
    .data_i  (bk_rsp),
    .full_o  (rs_full),
    .pop_i   (pop),
    .data_o  (rs_head),
    .empty_o (empty)
  );

  assign rsp_o = out_item_t'(rs_head);

endmodule
